/* src/lbp3_pkg.sv */
// lbp3_pkg: shared constants, register map and helpers for the 3x3 LBP operator.
// No dependencies; used by the stream interfaces and lbp_3x3_operator.
`default_nettype none

package lbp3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W   = 8;
	localparam int CODE_W  = 8;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 13;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index (paddr[2])
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(MAX_HEIGHT);

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		r = w;
		if (w < WIDTH_MIN)
			r = WIDTH_MIN;
		else if (w > WIDTH_MAX)
			r = WIDTH_MAX;
		return r;
	endfunction

	function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] h);
		logic [HEIGHT_W-1:0] r;
		r = h;
		if (h < HEIGHT_MIN)
			r = HEIGHT_MIN;
		else if (h > HEIGHT_MAX)
			r = HEIGHT_MAX;
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/lbp3_stream_if.sv */
// Valid/ready stream interfaces for the LBP operator: pixel input and code output.
// Depends on lbp3_pkg for field widths.
`default_nettype none

interface lbp3_pix_if;
	logic                         valid;
	logic                         ready;
	logic [lbp3_pkg::PIX_W-1:0]   pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp3_code_if;
	logic                         valid;
	logic                         ready;
	logic [lbp3_pkg::CODE_W-1:0]  lbp_code;
	logic [lbp3_pkg::COL_W-1:0]   center_column;
	logic                         last_in_frame;

	modport source (output valid, output lbp_code, output center_column,
		output last_in_frame, input ready);
	modport sink   (input valid, input lbp_code, input center_column,
		input last_in_frame, output ready);
endinterface

`default_nettype wire

/* src/lbp_3x3_operator.sv */
// lbp_3x3_operator: 3x3 8-neighbour local binary pattern over a raster pixel stream.
// Pixel accept to code valid passes the input register (stage 1), then the code register.
// Throughput 1 pixel per cycle; input held off only while a code waits on codes.ready.
// Reset (arst_n low) clears counters, window, pipeline valids; width/height go to 640/480.
// Line stores are not cleared; entries are written before any in-frame read uses them.
// Depends on lbp3_pkg and lbp3_stream_if.
`default_nettype none

module lbp_3x3_operator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// APB-style config port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lbp3_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lbp3_pkg::DATA_W-1:0]   pwdata,
	output      logic [lbp3_pkg::DATA_W-1:0]   prdata,
	output      logic                          pready,

	lbp3_pix_if.sink                           pixels,
	lbp3_code_if.source                        codes
);

	localparam int PW = lbp3_pkg::PIX_W;
	localparam int CW = lbp3_pkg::COL_W;
	localparam int RW = lbp3_pkg::ROW_W;
	localparam int WW = lbp3_pkg::WIDTH_W;
	localparam int HW = lbp3_pkg::HEIGHT_W;

	// ---------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbp3_pkg::WIDTH_RST;
			height_q <= lbp3_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lbp3_pkg::REG_WIDTH:  width_q  <= pwdata[WW-1:0];
				lbp3_pkg::REG_HEIGHT: height_q <= pwdata[HW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lbp3_pkg::REG_WIDTH:  prdata = {{(lbp3_pkg::DATA_W-WW){1'b0}}, width_q};
			lbp3_pkg::REG_HEIGHT: prdata = {{(lbp3_pkg::DATA_W-HW){1'b0}}, height_q};
			default:              prdata = '0;
		endcase
	end

	// effective frame size, clamped to the supported range
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	assign w_eff = lbp3_pkg::clamp_width(width_q);
	assign h_eff = lbp3_pkg::clamp_height(height_q);

	// ---------------------------------------------------------------
	// Handshake: stage 1 holds the accepted pixel plus its line-store
	// reads; it retires into the output register when that is free.
	// ---------------------------------------------------------------
	logic s1_valid_s1;
	logic s1_adv;
	logic in_acc;
	logic out_valid_q;

	assign s1_adv       = s1_valid_s1 & (~out_valid_q | codes.ready);
	assign pixels.ready = ~s1_valid_s1 | s1_adv;
	assign in_acc       = pixels.valid & pixels.ready;

	// ---------------------------------------------------------------
	// Raster position of the next pixel
	// ---------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_end;
	logic          row_end;

	assign col_end = ({1'b0, col_q} + WW'(1)) >= w_eff;
	assign row_end = ({1'b0, row_q} + HW'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Line stores: read at accept, written back when stage 1 retires.
	// Consecutive pixels always hit different columns (width >= 3),
	// so the write of one pixel never collides with the next read.
	// ---------------------------------------------------------------
	logic [PW-1:0] store_upper [lbp3_pkg::MAX_WIDTH];
	logic [PW-1:0] store_middle[lbp3_pkg::MAX_WIDTH];

	logic [PW-1:0] top_s1;
	logic [PW-1:0] mid_s1;
	logic [PW-1:0] bot_s1;
	logic [CW-1:0] col_s1;
	logic          has_res_s1;
	logic          last_s1;

	always_ff @(posedge clk) begin
		if (in_acc)
			top_s1 <= store_upper[col_q];
		if (s1_adv)
			store_upper[col_s1] <= mid_s1;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			mid_s1 <= store_middle[col_q];
		if (s1_adv)
			store_middle[col_s1] <= bot_s1;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bot_s1     <= pixels.pixel;
			col_s1     <= col_q;
			has_res_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1    <= row_end & col_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (pixels.ready)
			s1_valid_s1 <= pixels.valid;
	end

	// ---------------------------------------------------------------
	// 3x3 window: columns c-2 (w0..w2) and c-1 (w3..w5), top to bottom.
	// The new column c is top_s1/mid_s1/bot_s1.
	// ---------------------------------------------------------------
	logic [PW-1:0] w0_q, w1_q, w2_q, w3_q, w4_q, w5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0; w1_q <= '0; w2_q <= '0;
			w3_q <= '0; w4_q <= '0; w5_q <= '0;
		end else if (s1_adv) begin
			w0_q <= w3_q;
			w1_q <= w4_q;
			w2_q <= w5_q;
			w3_q <= top_s1;
			w4_q <= mid_s1;
			w5_q <= bot_s1;
		end
	end

	// code bits: centre <= neighbour, clockwise from top-left
	logic [lbp3_pkg::CODE_W-1:0] code_d;
	always_comb begin
		code_d[0] = w4_q <= w0_q;    // top-left
		code_d[1] = w4_q <= w3_q;    // top
		code_d[2] = w4_q <= top_s1;  // top-right
		code_d[3] = w4_q <= mid_s1;  // right
		code_d[4] = w4_q <= bot_s1;  // bottom-right
		code_d[5] = w4_q <= w5_q;    // bottom
		code_d[6] = w4_q <= w2_q;    // bottom-left
		code_d[7] = w4_q <= w1_q;    // left
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic [lbp3_pkg::CODE_W-1:0] code_q;
	logic [CW-1:0]               ccol_q;
	logic                        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= has_res_s1;
		else if (codes.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_res_s1) begin
			code_q <= code_d;
			ccol_q <= col_s1 - CW'(1);
			last_q <= last_s1;
		end
	end

	assign codes.valid         = out_valid_q;
	assign codes.lbp_code      = code_q;
	assign codes.center_column = ccol_q;
	assign codes.last_in_frame = last_q;

endmodule

`default_nettype wire

/* sim/lbp3_checker.sv */
// lbp3_checker: passive scoreboard for lbp_3x3_operator; follows the register port,
// predicts the code of every interior pixel and compares each returned item.
// Depends on lbp3_pkg.
module lbp3_checker
	import lbp3_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                pix_valid,
	input  logic                pix_ready,
	input  logic [PIX_W-1:0]    pix_data,
	input  logic                code_valid,
	input  logic                code_ready,
	input  logic [CODE_W-1:0]   code_value,
	input  logic [COL_W-1:0]    code_column,
	input  logic                code_last,
	output int                  mismatches,
	output int                  pending,
	output int                  codes_checked,
	output int                  frame_ends,
	output logic                frame_start
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [COL_W-1:0]  column;
		logic              last;
	} lbp_code_t;

	lbp_code_t          codes_due[$];
	logic [PIX_W-1:0]   upper_row [MAX_WIDTH];
	logic [PIX_W-1:0]   middle_row [MAX_WIDTH];
	// columns c-2 and c-1 of the window; index 0 top, 1 middle, 2 bottom
	logic [PIX_W-1:0]   far_col [3];
	logic [PIX_W-1:0]   near_col [3];
	int                 col_pos;
	int                 row_pos;
	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;

	task automatic lbp_predict_pixel(input logic [PIX_W-1:0] below_right);
		int w_eff;
		int h_eff;
		logic [PIX_W-1:0] above_right;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] center;
		lbp_code_t due;
		w_eff = width_reg;
		if (w_eff < int'(WIDTH_MIN))
			w_eff = WIDTH_MIN;
		else if (w_eff > MAX_WIDTH)
			w_eff = MAX_WIDTH;
		h_eff = height_reg;
		if (h_eff < int'(HEIGHT_MIN))
			h_eff = HEIGHT_MIN;
		else if (h_eff > MAX_HEIGHT)
			h_eff = MAX_HEIGHT;

		above_right = upper_row[col_pos];
		right       = middle_row[col_pos];
		if (row_pos >= 2 && col_pos >= 2) begin
			center   = near_col[1];
			due.code = {center <= far_col[1], center <= far_col[2], center <= near_col[2],
				center <= below_right, center <= right, center <= above_right,
				center <= near_col[0], center <= far_col[0]};
			due.column = COL_W'(col_pos - 1);
			due.last   = (row_pos + 1 >= h_eff) && (col_pos + 1 >= w_eff);
			codes_due  = {codes_due, due};
		end

		upper_row[col_pos]  = right;
		middle_row[col_pos] = below_right;
		far_col  = near_col;
		near_col = '{above_right, right, below_right};

		if (col_pos + 1 >= w_eff) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lbp_code_t due;
		if (!arst_n) begin
			codes_due.delete();
			far_col    = '{default: '0};
			near_col   = '{default: '0};
			col_pos    = 0;
			row_pos    = 0;
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
		end else begin
			if (code_valid && code_ready) begin
				codes_checked++;
				if (code_last)
					frame_ends++;
				if (codes_due.size() == 0) begin
					mismatches++;
					$display("%0t: code %h column %0d last %0d arrived with none expected",
						$time, code_value, code_column, code_last);
				end else begin
					due = codes_due.pop_front();
					if (code_value !== due.code) begin
						mismatches++;
						$display("%0t: lbp_code expected %h actual %h (column %0d)",
							$time, due.code, code_value, due.column);
					end
					if (code_column !== due.column) begin
						mismatches++;
						$display("%0t: center_column expected %0d actual %0d",
							$time, due.column, code_column);
					end
					if (code_last !== due.last) begin
						mismatches++;
						$display("%0t: last_in_frame expected %0d actual %0d (column %0d)",
							$time, due.last, code_last, due.column);
					end
				end
			end
			if (pix_valid && pix_ready)
				lbp_predict_pixel(pix_data);
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_WIDTH:  width_reg  = pwdata[WIDTH_W-1:0];
					REG_HEIGHT: height_reg = pwdata[HEIGHT_W-1:0];
				endcase
			end
		end
		pending     = codes_due.size();
		frame_start = (col_pos == 0) && (row_pos == 0);
	end

endmodule

/* sim/tb_top.sv */
// tb_top: stimulus and verdict for lbp_3x3_operator; drives pixels, register writes
// and output back-pressure, while lbp3_checker predicts and compares every code.
// Depends on lbp3_pkg, lbp3_stream_if, lbp_3x3_operator and lbp3_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lbp3_pkg::*;

	localparam int LONG_HOLD      = 300;   // receiver stall long enough to fill the block
	localparam int DRAIN_CYCLES   = 8;     // border pixels leave no trace
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lbp3_pix_if  pix_ch ();
	lbp3_code_if code_ch ();

	int   mismatches;
	int   codes_pending;
	int   codes_checked;
	int   frame_ends;
	logic frame_start;

	// knobs shared with the receiver process and send_pixel
	logic src_idle_on;
	logic sink_idle_on;
	int   holds_asked;
	int   holds_done;

	// stimulus bookkeeping
	int               cur_w;      // effective sizes as last written
	int               cur_h;
	int               pixels_sent;
	int               reg_writes;
	int               stall_cycles;
	logic [PIX_W-1:0] last_pix;

	lbp_3x3_operator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixels  (pix_ch),
		.codes   (code_ch)
	);

	lbp3_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pix_valid     (pix_ch.valid),
		.pix_ready     (pix_ch.ready),
		.pix_data      (pix_ch.pixel),
		.code_valid    (code_ch.valid),
		.code_ready    (code_ch.ready),
		.code_value    (code_ch.lbp_code),
		.code_column   (code_ch.center_column),
		.code_last     (code_ch.last_in_frame),
		.mismatches    (mismatches),
		.pending       (codes_pending),
		.codes_checked (codes_checked),
		.frame_ends    (frame_ends),
		.frame_start   (frame_start)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any accepted item on either channel restarts the count. A code that
	// never shows up, or a block that never takes a pixel, ends the run here.
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (code_ch.valid && code_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d codes still due",
				WATCHDOG_LIMIT, codes_pending);
			$display("FAIL");
			$finish;
		end
	end

	// Receiver side: random ready bursts, plus a long hold when stimulus asks for one.
	// Each branch ends by setting ready at a falling edge; the loop then waits for the next one.
	initial begin : receiver
		int n;
		code_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done < holds_asked) begin
				code_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
				code_ch.ready <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, 14);
				code_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
				code_ch.ready <= 1'b1;
			end else begin
				code_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int fit(input int v, input int lo, input int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// Pixel mix: half uniform, with extra flats (repeats) and rail values so the
	// center <= neighbour compare hits the equal case often.
	function automatic logic [PIX_W-1:0] next_pixel();
		case ($urandom_range(0, 7))
			0: last_pix = '0;
			1: last_pix = '1;
			2, 3: last_pix = last_pix;
			default: last_pix = PIX_W'($urandom);
		endcase
		return last_pix;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so back-to-back items see no bubble.
	task automatic send_pixel(input logic [PIX_W-1:0] value);
		int gap;
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= value;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	// Finish the current frame, n times over; the checker tracks the raster position.
	task automatic send_frames(input int n);
		repeat (n) begin
			do
				send_pixel(next_pixel());
			while (!frame_start);
		end
	endtask

	// Sender pause: drop valid and wait until every predicted code has come back,
	// then cover the pipeline in case the last pixels were border ones.
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		while (codes_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Setup and access phase, then an idle phase with psel low. Bits above the register width
	// carry junk, which the block must drop.
	task automatic apb_write(input logic idx, input int value);
		logic [DATA_W-1:0] junk;
		junk = (idx == REG_WIDTH) ? ~((DATA_W'(1) << WIDTH_W) - 1)
			: ~((DATA_W'(1) << HEIGHT_W) - 1);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= (DATA_W'($urandom) & junk) | DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		if (idx == REG_WIDTH)
			cur_w = fit(value, WIDTH_MIN, MAX_WIDTH);
		else
			cur_h = fit(value, HEIGHT_MIN, MAX_HEIGHT);
		reg_writes++;
	endtask

	task automatic set_size(input int w, input int h);
		apb_write(REG_WIDTH, w);
		apb_write(REG_HEIGHT, h);
	endtask

	// Stop part way into a frame, let the block go idle, and resize it there.
	// Height may move either way. Width never grows: growing it mid-frame would
	// read line store entries that were never written.
	task automatic resize_mid_frame();
		int cut;
		cut = $urandom_range(1, cur_w * cur_h - 1);
		repeat (cut) send_pixel(next_pixel());
		wait_drained();
		apb_write(REG_HEIGHT, $urandom_range(0, 12));
		if ($urandom_range(0, 1))
			apb_write(REG_WIDTH, $urandom_range(0, cur_w));
		do
			send_pixel(next_pixel());
		while (!frame_start);
	endtask

	initial begin : stimulus
		logic [PIX_W-1:0] mixed_win [9];
		mixed_win    = '{8'd255, 8'd254, 8'd0,
			8'd255, 8'd255, 8'd128,
			8'd1,   8'd255, 8'd255};
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		holds_asked  = 0;
		holds_done   = 0;
		pixels_sent  = 0;
		reg_writes   = 0;
		last_pix     = '0;
		cur_w        = WIDTH_RST;
		cur_h        = HEIGHT_RST;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: smallest frame, a flat image where every compare is equal,
		// then a mixed window with the center at full scale. The second frame uses
		// under-range register values, which must behave as 3x3.
		set_size(3, 3);
		repeat (9) send_pixel('0);
		wait_drained();
		set_size(1, 0);
		foreach (mixed_win[i])
			send_pixel(mixed_win[i]);

		// Back-pressure: receiver stalls for a long stretch while pixels keep coming.
		wait_drained();
		set_size(8, 6);
		holds_asked++;
		send_frames(2);

		// Random sizes, small frames, one to two each; at least one resize mid-frame.
		for (int i = 0; i < 3; i++) begin
			wait_drained();
			set_size($urandom_range(0, 18), $urandom_range(0, 10));
			send_frames($urandom_range(1, 2));
			if (i == 0 || $urandom_range(0, 1))
				resize_mid_frame();
		end

		// Over-range sizes: width clamps to a full line, height to the tallest frame.
		// Part of the first row goes in, then width shrinks to a small value so the
		// row wraps at once, and later height drops below the current row.
		wait_drained();
		set_size(2047, 8191);
		repeat (40) send_pixel(next_pixel());
		wait_drained();
		apb_write(REG_WIDTH, 5);
		repeat (30) send_pixel(next_pixel());
		wait_drained();
		apb_write(REG_HEIGHT, 4);
		do
			send_pixel(next_pixel());
		while (!frame_start);

		// Tail with both sides streaming at full rate.
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		wait_drained();
		set_size($urandom_range(3, 14), $urandom_range(3, 8));
		send_frames(2);
		wait_drained();

		$display("Run covered %0d pixels and %0d register writes, incl. clamped and mid-frame sizes",
			pixels_sent, reg_writes);
		$display("Checked %0d codes, %0d frame-end flags, %0d mismatches",
			codes_checked, frame_ends, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* lbp_3x3_operator.f */
src/lbp3_pkg.sv
src/lbp3_stream_if.sv
src/lbp_3x3_operator.sv
sim/lbp3_checker.sv
sim/tb_top.sv
